>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is low.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked on every rising edge, switched off while reset is low.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/frad_pkg.sv
// Shared widths, constants and types for the averaging decimator.
// No dependencies; imported by every module of the block.
package frad_pkg;

	localparam int FRAME_INDEX_BITS = 24;
	localparam int COUNT_BITS       = 13;
	localparam int SAMPLE_BITS      = 16;
	localparam int STEP_BITS        = 28;
	localparam int SLACK_BITS       = 29;
	localparam int SUM_BITS         = COUNT_BITS + SAMPLE_BITS;
	// |sum| stays below 2^(SUM_BITS-1): one bit less carries the magnitude
	localparam int MAG_BITS         = SUM_BITS - 1;
	localparam int ITER_BITS        = $clog2(MAG_BITS);
	localparam int QUEUE_DEPTH      = 4;
	localparam int QPTR_BITS        = $clog2(QUEUE_DEPTH);

	localparam logic [STEP_BITS-1:0]  STEP_RESET = STEP_BITS'(21277901);
	localparam logic [SLACK_BITS-1:0] ONE_TICK   = SLACK_BITS'(65536);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

	// One closed frame waiting for its division
	typedef struct packed {
		logic signed [SUM_BITS-1:0]   sum;
		logic [COUNT_BITS-1:0]        count;
		logic [FRAME_INDEX_BITS-1:0]  index;
	} frad_job_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} frad_qstat_t;

endpackage

>>> rtl/frad_front.sv
// Front end: takes samples, keeps sum, count, slack and frame number,
// pushes one job per closed frame. Depends on frad_pkg.
module frad_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [frad_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [frad_pkg::STEP_BITS-1:0]         ticks_per_frame_q16,
	input  frad_pkg::frad_qstat_t                  qstat,
	output logic                                   push,
	output frad_pkg::frad_job_t                    job
);
	import frad_pkg::*;

	logic [STEP_BITS-1:0]        step_q;
	logic [SLACK_BITS-1:0]       slack_q;
	logic signed [SUM_BITS-1:0]  sum_q;
	logic [COUNT_BITS-1:0]       count_q;
	logic [FRAME_INDEX_BITS-1:0] frame_q;

	logic                        accept;
	logic                        closes;
	logic signed [SUM_BITS-1:0]  sum_add;
	logic [COUNT_BITS-1:0]       count_add;
	logic [SLACK_BITS-1:0]       slack_add;

	// negative slack means this beat closes a frame; stall only if it cannot be queued
	assign closes    = slack_q[SLACK_BITS-1];
	assign in_ready  = !(closes && qstat.full);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// sample is dropped once the count saturates
	always_comb begin
		if (count_q != COUNT_MAX) begin
			sum_add   = sum_q + SUM_BITS'(sample_in);
			count_add = count_q + COUNT_BITS'(1);
		end else begin
			sum_add   = sum_q;
			count_add = count_q;
		end
		slack_add = closes ? slack_q + {1'b0, step_q} : slack_q;
	end

	assign push = accept && closes;
	assign job  = '{sum: sum_add, count: count_add, index: frame_q};

	// step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_valid) begin
			step_q <= ticks_per_frame_q16;
		end
	end

	// running accumulation and slack, wrapping in SLACK_BITS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slack_q <= '0;
			sum_q   <= '0;
			count_q <= '0;
			frame_q <= '0;
		end else if (accept) begin
			slack_q <= slack_add - ONE_TICK;
			if (closes) begin
				sum_q   <= '0;
				count_q <= '0;
				frame_q <= frame_q + FRAME_INDEX_BITS'(1);
			end else begin
				sum_q   <= sum_add;
				count_q <= count_add;
			end
		end
	end

endmodule

>>> rtl/frad_queue.sv
// Short job queue between front end and divider.
// Depends on frad_pkg.
module frad_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  frad_pkg::frad_job_t   job_in,
	input  logic                  pop,
	output frad_pkg::frad_job_t   job_out,
	output frad_pkg::frad_qstat_t qstat
);
	import frad_pkg::*;

	frad_job_t            entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q;
	logic [QPTR_BITS-1:0] rd_q;
	logic [QPTR_BITS:0]   fill_q;

	assign qstat.full  = (fill_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign qstat.empty = (fill_q == '0);
	assign job_out     = entry_q[rd_q];

	// entries carry no reset
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= job_in;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_BITS'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + (QPTR_BITS+1)'(1);
				2'b01:   fill_q <= fill_q - (QPTR_BITS+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

>>> rtl/frad_divider.sv
// Back end: serial restoring divider, one quotient bit per cycle, and the
// output register. Depends on frad_pkg.
module frad_divider (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  frad_pkg::frad_qstat_t                      qstat,
	input  frad_pkg::frad_job_t                        job,
	output logic                                       pop,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic signed [frad_pkg::SAMPLE_BITS-1:0]    frame_average,
	output logic [frad_pkg::FRAME_INDEX_BITS-1:0]      frame_index
);
	import frad_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_HOLD
	} state_t;

	state_t                      state_q;
	logic                        neg_q;
	logic [MAG_BITS-1:0]         quo_q;
	logic [COUNT_BITS-1:0]       rem_q;
	logic [COUNT_BITS-1:0]       div_q;
	logic [ITER_BITS-1:0]        iter_q;
	logic [FRAME_INDEX_BITS-1:0] idx_q;
	logic                        out_valid_q;
	logic signed [SAMPLE_BITS-1:0] avg_q;
	logic [FRAME_INDEX_BITS-1:0] out_idx_q;

	logic signed [SUM_BITS-1:0]  sum_neg;
	logic [MAG_BITS-1:0]         mag;
	logic [COUNT_BITS:0]         rem_shift;
	logic                        fits;
	logic [COUNT_BITS:0]         rem_sub;
	logic [SAMPLE_BITS-1:0]      quo_lo;
	logic                        out_free;

	assign pop       = (state_q == S_IDLE) && !qstat.empty;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign frame_average = avg_q;
	assign frame_index   = out_idx_q;

	// magnitude of the frame sum
	always_comb begin
		sum_neg = -job.sum;
		mag     = job.sum[SUM_BITS-1] ? MAG_BITS'(sum_neg) : MAG_BITS'(job.sum);
	end

	// one restoring step
	always_comb begin
		rem_shift = {rem_q, quo_q[MAG_BITS-1]};
		rem_sub   = rem_shift - {1'b0, div_q};
		fits      = (rem_shift >= {1'b0, div_q});
		quo_lo    = quo_q[SAMPLE_BITS-1:0];
	end

	// output valid: set when a result is loaded, cleared once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_HOLD) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer with output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			neg_q       <= 1'b0;
			quo_q       <= '0;
			rem_q       <= '0;
			div_q       <= '0;
			iter_q      <= '0;
			idx_q       <= '0;
			avg_q       <= '0;
			out_idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!qstat.empty) begin
						neg_q   <= job.sum[SUM_BITS-1];
						quo_q   <= mag;
						rem_q   <= '0;
						div_q   <= job.count;
						idx_q   <= job.index;
						iter_q  <= ITER_BITS'(MAG_BITS - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					quo_q <= {quo_q[MAG_BITS-2:0], fits};
					rem_q <= fits ? rem_sub[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
					if (iter_q == '0) begin
						state_q <= S_HOLD;
					end else begin
						iter_q <= iter_q - ITER_BITS'(1);
					end
				end
				S_HOLD: begin
					// quotient magnitude never exceeds 2^15, so 16 bits carry it
					if (out_free) begin
						avg_q       <= neg_q ? -quo_lo : quo_lo;
						out_idx_q   <= idx_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/fractional_rate_averaging_decimator.sv
// Top level of the fractional-rate averaging decimator.
// Depends on frad_pkg, frad_front, frad_queue, frad_divider.
//
//  channel  signals                                   beat
//  in       in_valid/in_ready, sample_in              one sample per tick
//  cfg      cfg_valid/cfg_ready, ticks_per_frame_q16  step, Q12.16
//  out      out_valid/out_ready, frame_average,       one closed frame
//           frame_index
//
// Samples are taken one per cycle; the front end stalls only when a beat
// closes a frame and the four-entry job queue is full.
// The serial divider takes one job at a time, through idle, divide and hold, so
// frames closing faster than it finishes them back up into the queue.
// cfg_ready is always high. Reset is asynchronous and needs no clearing pass.
module fractional_rate_averaging_decimator (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [frad_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [frad_pkg::STEP_BITS-1:0]          ticks_per_frame_q16,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [frad_pkg::SAMPLE_BITS-1:0] frame_average,
	output logic [frad_pkg::FRAME_INDEX_BITS-1:0]   frame_index
);
	import frad_pkg::*;

	frad_qstat_t qstat;
	frad_job_t   push_job;
	frad_job_t   head_job;
	logic        push;
	logic        pop;

	frad_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.sample_in           (sample_in),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.ticks_per_frame_q16 (ticks_per_frame_q16),
		.qstat               (qstat),
		.push                (push),
		.job                 (push_job)
	);

	frad_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (push_job),
		.pop     (pop),
		.job_out (head_job),
		.qstat   (qstat)
	);

	frad_divider u_div (
		.clk           (clk),
		.arst_n        (arst_n),
		.qstat         (qstat),
		.job           (head_job),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_average (frame_average),
		.frame_index   (frame_index)
	);

endmodule

>>> rtl/frad_checker.sv
// Port-level checks for the averaging decimator, bound to the top level.
// Depends on frad_pkg and assert_macros.svh.
`include "assert_macros.svh"

module frad_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_ready,
	input logic signed [frad_pkg::SAMPLE_BITS-1:0] sample_in,
	input logic                                    cfg_valid,
	input logic                                    cfg_ready,
	input logic [frad_pkg::STEP_BITS-1:0]          ticks_per_frame_q16,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic signed [frad_pkg::SAMPLE_BITS-1:0] frame_average,
	input logic [frad_pkg::FRAME_INDEX_BITS-1:0]   frame_index
);
	import frad_pkg::*;

	logic [FRAME_INDEX_BITS-1:0] exp_idx_q;

	// next frame number expected on the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (out_valid && out_ready) begin
			exp_idx_q <= exp_idx_q + FRAME_INDEX_BITS'(1);
		end
	end

	`ASSERT_CLK(a_cfg_always_ready, cfg_ready, "config port not ready")
	`ASSERT_IMPL(a_index_in_order, out_valid, frame_index == exp_idx_q, "frame index out of order")
	`ASSERT_IMPL(a_out_held, out_valid && !out_ready, ##1 out_valid, "output beat dropped")
	`ASSERT_IMPL(a_out_stable, out_valid && !out_ready, ##1 ($stable(frame_average) && $stable(frame_index)), "stalled output changed")

endmodule

bind fractional_rate_averaging_decimator frad_checker u_frad_checker (.*);

>>> dv/fractional_rate_averaging_decimator_tb.sv
// Self-checking bench for the fractional-rate averaging decimator: random samples per phase,
// step register rewritten between phases, frames checked against an in-bench predictor.
// Depends on frad_pkg and fractional_rate_averaging_decimator.
module fractional_rate_averaging_decimator_tb;

	localparam int SMP_W  = frad_pkg::SAMPLE_BITS;
	localparam int IDX_W  = frad_pkg::FRAME_INDEX_BITS;
	localparam int STEP_W = frad_pkg::STEP_BITS;
	localparam int SLK_W  = frad_pkg::SLACK_BITS;
	localparam int SUM_W  = frad_pkg::SUM_BITS;
	localparam int CNT_W  = frad_pkg::COUNT_BITS;

	localparam logic [STEP_W-1:0] STEP_AT_RESET = 28'd21277901;
	localparam int unsigned       STEP_MAX      = 32'h0FFF_FFFF;
	localparam int                ONE_TICK_Q16  = 65536;
	localparam int                PHASES        = 9;
	localparam int                SETTLE_CYCLES = 40;

	typedef struct {
		logic signed [SMP_W-1:0] average;
		logic [IDX_W-1:0]        index;
	} frame_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [SMP_W-1:0]  sample_in = '0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [STEP_W-1:0]        ticks_per_frame_q16 = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [SMP_W-1:0]  frame_average;
	logic [IDX_W-1:0]         frame_index;

	// beats seen at the last rising edge
	logic in_beat = 1'b0;
	logic cfg_beat = 1'b0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count = 0;

	// predictor state
	logic [STEP_W-1:0]        step_q16 = STEP_AT_RESET;
	logic signed [SLK_W-1:0]  slack_q16 = '0;
	logic signed [SUM_W-1:0]  sample_sum = '0;
	logic [CNT_W-1:0]         sample_count = '0;
	logic [IDX_W-1:0]         frame_no = '0;

	frame_t                   frames_due[$];
	logic signed [SMP_W-1:0]  samples_pending[$];
	frame_t                   due;

	fractional_rate_averaging_decimator u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.sample_in           (sample_in),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.ticks_per_frame_q16 (ticks_per_frame_q16),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.frame_average       (frame_average),
		.frame_index         (frame_index)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// One tick of the decimator: gather the sample, close a frame when the slack is negative
	task automatic average_tick(input logic signed [SMP_W-1:0] smp);
		logic signed [SUM_W-1:0] quotient;
		// a full count drops the sample
		if (sample_count != '1) begin
			sample_sum   = sample_sum + smp;
			sample_count = sample_count + 1'b1;
		end
		if (slack_q16 < 0) begin
			// count is never zero here; division truncates toward zero
			quotient = sample_sum / $signed({1'b0, sample_count});
			frames_due.push_back('{quotient[SMP_W-1:0], frame_no});
			frame_no     = frame_no + 1'b1;
			slack_q16    = slack_q16 + $signed({1'b0, step_q16});
			sample_sum   = '0;
			sample_count = '0;
		end
		slack_q16 = slack_q16 - SLK_W'(ONE_TICK_Q16);
	endtask

	// Driver: presents pending samples, idles and stalls the result side at random
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_beat) begin
			if (samples_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid  <= 1'b1;
				sample_in <= samples_pending.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// Monitor: tracks register writes and samples, checks each frame beat
	always @(posedge clk) begin
		in_beat  <= in_valid && in_ready;
		cfg_beat <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				step_q16 = ticks_per_frame_q16;
			if (in_valid && in_ready)
				average_tick(sample_in);
			if (out_valid && out_ready) begin
				if (frames_due.size() == 0) begin
					$display("%0t: frame beat with none expected, average %0d index %0d",
						$time, frame_average, frame_index);
					fail_count++;
				end else begin
					due = frames_due.pop_front();
					if (frame_average !== due.average) begin
						$display("%0t: frame_average expected %0d, got %0d",
							$time, due.average, frame_average);
						fail_count++;
					end
					if (frame_index !== due.index) begin
						$display("%0t: frame_index expected %0d, got %0d",
							$time, due.index, frame_index);
						fail_count++;
					end
				end
			end
		end
	end

	// Stimulus: one step setting per phase, written only while the block is quiet
	initial begin
		logic signed [SMP_W-1:0] opening [13];
		int unsigned             step_plan [PHASES];
		int                      item_plan [PHASES];
		logic signed [SMP_W-1:0] next_sample;

		// extremes first; the first frame averages the two rails
		opening = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh5555,
			16'shAAAA, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0002, 16'shFFFD};
		// reset step, exactly one tick, a fractional step, under one tick, three more fractional
		// steps, zero (a frame every tick), then the largest step
		step_plan = '{STEP_AT_RESET, ONE_TICK_Q16,
			$urandom_range(ONE_TICK_Q16 + 1, 4 * ONE_TICK_Q16), 1,
			$urandom_range(ONE_TICK_Q16 + 1, 4 * ONE_TICK_Q16),
			$urandom_range(ONE_TICK_Q16 + 1, 4 * ONE_TICK_Q16),
			$urandom_range(ONE_TICK_Q16 + 1, 4 * ONE_TICK_Q16), 0, STEP_MAX};
		item_plan = '{40, 60, 60, 30, 60, 60, 60, 40, 40};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			send_idle_pct = (p < 3) ? 38 : (p < 6) ? 55 : 0;
			recv_idle_pct = (p < 3) ? 55 : (p < 6) ? 38 : 0;
			// first phase runs on the reset value of the step
			if (p != 0) begin
				cfg_valid           <= 1'b1;
				ticks_per_frame_q16 <= step_plan[p][STEP_W-1:0];
				do @(negedge clk); while (!cfg_beat);
				cfg_valid <= 1'b0;
			end
			for (int i = 0; i < item_plan[p]; i++) begin
				case ($urandom_range(7))
					0: begin
						next_sample = 16'sh8000;
					end
					1: begin
						next_sample = 16'sh7FFF;
					end
					default: begin
						next_sample = SMP_W'($urandom);
					end
				endcase
				if (p == 0 && i < $size(opening))
					next_sample = opening[i];
				samples_pending.push_back(next_sample);
			end
			// drain, then let the divider settle before the next register write
			while (samples_pending.size() != 0 || in_valid || frames_due.size() != 0)
				@(negedge clk);
			repeat (SETTLE_CYCLES) @(negedge clk);
		end

		if (fail_count == 0 && frames_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
